// ----- hdl/sv39ptm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sv39ptm_pkg;

    // Pool geometry.
    localparam int POOL_TABLES   = 16;
    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TBL_W         = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CNT_W         = $clog2(POOL_TABLES + 1);
    localparam int DEPTH         = POOL_TABLES * TABLE_ENTRIES;
    localparam int ADDR_W        = $clog2(DEPTH);

    // Field widths.
    localparam int PTE_W    = 54;
    localparam int PPN_W    = 44;
    localparam int FLAG_W   = 10;
    localparam int VA_W     = 39;
    localparam int PA_W     = 56;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_MAP_4K   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MAP_2M   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MAP_1G   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNMAP_4K = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNALIGNED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EXISTS    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOMAP     = 3'd4;

    // Walk levels.
    localparam logic [1:0] LVL_4K = 2'd0;
    localparam logic [1:0] LVL_2M = 2'd1;
    localparam logic [1:0] LVL_1G = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    // Decoded view of one table entry.
    typedef struct packed {
        logic             valid;
        logic             leaf;
        logic             in_pool;
        logic [TBL_W-1:0] table_idx;
        logic [PPN_W-1:0] ppn;
    } t_pte_info;

endpackage

`default_nettype wire

// ----- hdl/sv39ptm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Single-port RAM with registered read data.
module sv39ptm_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 54
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/sv39ptm_pte_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared entry decoder: used once per walk level on the word just read.
module sv39ptm_pte_eval (
    input  wire logic [sv39ptm_pkg::PTE_W-1:0] i_pte,
    input  wire logic [sv39ptm_pkg::PPN_W-1:0] i_base,
    output sv39ptm_pkg::t_pte_info             o_info
);

    logic [sv39ptm_pkg::PPN_W-1:0] ppn;
    logic [sv39ptm_pkg::PPN_W-1:0] offset;

    // Offset of the named page from the pool base, modulo the PPN width.
    assign ppn    = i_pte[sv39ptm_pkg::PTE_W-1:sv39ptm_pkg::FLAG_W];
    assign offset = ppn - i_base;

    assign o_info.valid     = i_pte[0];
    assign o_info.leaf      = |i_pte[3:1];
    assign o_info.in_pool   = offset < sv39ptm_pkg::PPN_W'(sv39ptm_pkg::POOL_TABLES);
    assign o_info.table_idx = offset[sv39ptm_pkg::TBL_W-1:0];
    assign o_info.ppn       = ppn;

endmodule

`default_nettype wire

// ----- hdl/sv39ptm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Walk sequencer: clears the table memory after reset, then runs one
// request at a time through up to three read and evaluate steps.
module sv39ptm_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [sv39ptm_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [sv39ptm_pkg::VA_W-1:0]      i_va,
    input  wire logic [sv39ptm_pkg::PA_W-1:0]      i_pa,
    input  wire logic [sv39ptm_pkg::FLAG_W-1:0]    i_flags,
    input  wire logic [sv39ptm_pkg::PPN_W-1:0]     i_base,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [sv39ptm_pkg::STATUS_W-1:0]  o_status,
    output logic      [sv39ptm_pkg::PA_W-1:0]      o_unmapped_pa,
    output logic                                   o_mem_en,
    output logic                                   o_mem_we,
    output logic      [sv39ptm_pkg::ADDR_W-1:0]    o_mem_addr,
    output logic      [sv39ptm_pkg::PTE_W-1:0]     o_mem_wdata,
    input  wire sv39ptm_pkg::t_pte_info            i_info
);

    localparam int PPN_W = sv39ptm_pkg::PPN_W;
    localparam logic [1:0] LVL_SEL_4K = sv39ptm_pkg::LVL_4K;
    localparam logic [1:0] LVL_SEL_2M = sv39ptm_pkg::LVL_2M;

    sv39ptm_pkg::t_state r_state, n_state;

    logic [sv39ptm_pkg::ADDR_W-1:0]   r_clr,       n_clr;
    logic [sv39ptm_pkg::CNT_W-1:0]    r_next_free, n_next_free;
    logic [1:0]                       r_level,     n_level;
    logic [sv39ptm_pkg::TBL_W-1:0]    r_table,     n_table;
    logic [sv39ptm_pkg::REQ_W-1:0]    r_req_type;
    logic [sv39ptm_pkg::VA_W-1:0]     r_va;
    logic [sv39ptm_pkg::PA_W-1:0]     r_pa;
    logic [sv39ptm_pkg::FLAG_W-1:0]   r_flags;
    logic [sv39ptm_pkg::STATUS_W-1:0] r_status,    n_status;
    logic [sv39ptm_pkg::PA_W-1:0]     r_removed,   n_removed;
    logic                             r_out_valid, n_out_valid;
    logic [sv39ptm_pkg::STATUS_W-1:0] r_out_status;
    logic [sv39ptm_pkg::PA_W-1:0]     r_out_pa;

    logic [sv39ptm_pkg::IDX_W-1:0] idx;
    logic [1:0]                    target_level;
    logic                          at_target;
    logic                          unaligned;
    logic                          pool_full;
    logic                          out_load;
    logic                          ev_done;
    logic [PPN_W-1:0]              alloc_ppn;
    logic [sv39ptm_pkg::PTE_W-1:0] ptr_pte;
    logic [sv39ptm_pkg::PTE_W-1:0] leaf_pte;

    // Table index for the current level.
    always_comb begin
        case (r_level)
            LVL_SEL_4K: idx = r_va[20:12];
            LVL_SEL_2M: idx = r_va[29:21];
            default:    idx = r_va[38:30];
        endcase
    end

    // Level at which the leaf lives for this request.
    always_comb begin
        case (r_req_type)
            sv39ptm_pkg::REQ_MAP_1G: target_level = sv39ptm_pkg::LVL_1G;
            sv39ptm_pkg::REQ_MAP_2M: target_level = sv39ptm_pkg::LVL_2M;
            default:                 target_level = sv39ptm_pkg::LVL_4K;
        endcase
    end

    // Alignment of va and pa to the page size; an unmap checks only va.
    always_comb begin
        case (r_req_type)
            sv39ptm_pkg::REQ_MAP_4K: unaligned = (|r_va[11:0]) | (|r_pa[11:0]);
            sv39ptm_pkg::REQ_MAP_2M: unaligned = (|r_va[20:0]) | (|r_pa[20:0]);
            sv39ptm_pkg::REQ_MAP_1G: unaligned = (|r_va[29:0]) | (|r_pa[29:0]);
            default:                 unaligned = |r_va[11:0];
        endcase
    end

    assign at_target = (r_level == target_level);
    assign pool_full = (r_next_free >= sv39ptm_pkg::CNT_W'(sv39ptm_pkg::POOL_TABLES));
    assign out_load  = (r_state == sv39ptm_pkg::S_DONE) && (!r_out_valid || i_out_ready);
    assign alloc_ppn = i_base + PPN_W'(r_next_free);
    assign ptr_pte   = {alloc_ppn, 9'd0, 1'b1};
    assign leaf_pte  = {r_pa[sv39ptm_pkg::PA_W-1:12], r_flags | 10'd1};

    // The walk ends at the target level or at the first failing upper entry.
    always_comb begin
        if (at_target) begin
            ev_done = 1'b1;
        end else if (!i_info.valid) begin
            ev_done = (r_req_type == sv39ptm_pkg::REQ_UNMAP_4K) || pool_full;
        end else begin
            ev_done = i_info.leaf || !i_info.in_pool;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sv39ptm_pkg::S_CLEAR: begin
                if (r_clr == sv39ptm_pkg::ADDR_W'(sv39ptm_pkg::DEPTH - 1)) begin
                    n_state = sv39ptm_pkg::S_IDLE;
                end
            end
            sv39ptm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sv39ptm_pkg::S_CHECK;
                end
            end
            sv39ptm_pkg::S_CHECK: begin
                n_state = unaligned ? sv39ptm_pkg::S_DONE : sv39ptm_pkg::S_READ;
            end
            sv39ptm_pkg::S_READ: begin
                n_state = sv39ptm_pkg::S_EVAL;
            end
            sv39ptm_pkg::S_EVAL: begin
                n_state = ev_done ? sv39ptm_pkg::S_DONE : sv39ptm_pkg::S_READ;
            end
            sv39ptm_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = sv39ptm_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Memory controls and datapath updates.
    always_comb begin
        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = sv39ptm_pkg::ADDR_W'({r_table, idx});
        o_mem_wdata = '0;
        n_clr       = r_clr;
        n_next_free = r_next_free;
        n_level     = r_level;
        n_table     = r_table;
        n_status    = r_status;
        n_removed   = r_removed;
        unique case (r_state)
            sv39ptm_pkg::S_CLEAR: begin
                o_mem_en   = 1'b1;
                o_mem_we   = 1'b1;
                o_mem_addr = r_clr;
                n_clr      = r_clr + 1'b1;
            end
            sv39ptm_pkg::S_IDLE: begin
                n_level = sv39ptm_pkg::LVL_1G;
                n_table = '0;
            end
            sv39ptm_pkg::S_CHECK: begin
                n_status  = unaligned ? sv39ptm_pkg::STATUS_UNALIGNED : sv39ptm_pkg::STATUS_OK;
                n_removed = '0;
            end
            sv39ptm_pkg::S_READ: begin
                o_mem_en = 1'b1;
            end
            sv39ptm_pkg::S_EVAL: begin
                if (at_target) begin
                    if (r_req_type == sv39ptm_pkg::REQ_UNMAP_4K) begin
                        // Remove the leaf and report its address.
                        if (!i_info.valid) begin
                            n_status = sv39ptm_pkg::STATUS_NOMAP;
                        end else begin
                            o_mem_en  = 1'b1;
                            o_mem_we  = 1'b1;
                            n_removed = {i_info.ppn, 12'd0};
                        end
                    end else if (i_info.valid) begin
                        n_status = sv39ptm_pkg::STATUS_EXISTS;
                    end else begin
                        o_mem_en    = 1'b1;
                        o_mem_we    = 1'b1;
                        o_mem_wdata = leaf_pte;
                    end
                end else if (!i_info.valid) begin
                    if (r_req_type == sv39ptm_pkg::REQ_UNMAP_4K) begin
                        n_status = sv39ptm_pkg::STATUS_NOMAP;
                    end else if (pool_full) begin
                        n_status = sv39ptm_pkg::STATUS_EXHAUSTED;
                    end else begin
                        // Hand out the next pool table and link it in.
                        o_mem_en    = 1'b1;
                        o_mem_we    = 1'b1;
                        o_mem_wdata = ptr_pte;
                        n_table     = r_next_free[sv39ptm_pkg::TBL_W-1:0];
                        n_next_free = r_next_free + 1'b1;
                        n_level     = r_level - 2'd1;
                    end
                end else if (i_info.leaf) begin
                    n_status = sv39ptm_pkg::STATUS_EXISTS;
                end else if (!i_info.in_pool) begin
                    n_status = (r_req_type == sv39ptm_pkg::REQ_UNMAP_4K) ?
                               sv39ptm_pkg::STATUS_NOMAP : sv39ptm_pkg::STATUS_EXISTS;
                end else begin
                    n_table = i_info.table_idx;
                    n_level = r_level - 2'd1;
                end
            end
            sv39ptm_pkg::S_DONE: begin
            end
        endcase
    end

    // Output register: a finished result waits here while the next item starts.
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sv39ptm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_next_free <= sv39ptm_pkg::CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level   <= n_level;
        r_table   <= n_table;
        r_status  <= n_status;
        r_removed <= n_removed;
        if (r_state == sv39ptm_pkg::S_IDLE && i_in_valid) begin
            r_req_type <= i_req_type;
            r_va       <= i_va;
            r_pa       <= i_pa;
            r_flags    <= i_flags;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_pa     <= r_removed;
        end
    end

    assign o_in_ready    = (r_state == sv39ptm_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_unmapped_pa = r_out_pa;

endmodule

`default_nettype wire

// ----- hdl/sv39_page_table_mapper_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel      Direction  Handshake                  Payload
// s_axis       in         s_axis_tvalid/tready       request item (type, va, pa, flags)
// m_axis       out        m_axis_tvalid/tready       result item (status, unmapped_pa)
// APB          in         psel/penable/pready        pool_base_ppn at byte address 0
//
// An item runs through a check step, then a read and an evaluate step for each of
// up to three table levels through the single table memory port, and a final step
// that hands the result over; an unaligned item goes straight from check to hand-over.
// The block then returns to idle, where the next item is accepted.
// After reset the table memory is cleared one entry a cycle, all POOL_TABLES * 512
// entries (8192), with s_axis_tready low; configuration writes are taken meanwhile.
// A result waits in the output register while the next item is accepted; a new
// result stalls in its done state only while the previous one is still untaken.
module sv39_page_table_mapper_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: va [38:0], pa [94:39], flags [104:95], zero fill [111:105]
    input  wire logic [111:0] s_axis_tdata,
    // tuser: req_type [1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: status [2:0], unmapped_pa [58:3], zero fill [63:59]
    output logic      [63:0]  m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic      [63:0]  prdata,
    output logic              pready
);

    localparam int PPN_W = sv39ptm_pkg::PPN_W;

    logic [PPN_W-1:0] r_pool_base;

    logic                             mem_en;
    logic                             mem_we;
    logic [sv39ptm_pkg::ADDR_W-1:0]   mem_addr;
    logic [sv39ptm_pkg::PTE_W-1:0]    mem_wdata;
    logic [sv39ptm_pkg::PTE_W-1:0]    mem_rdata;
    sv39ptm_pkg::t_pte_info           pte_info;
    logic [sv39ptm_pkg::STATUS_W-1:0] out_status;
    logic [sv39ptm_pkg::PA_W-1:0]     out_pa;
    logic                             reg_sel;

    // Register file: one register, pool_base_ppn, in the first 8-byte slot.
    assign reg_sel = !paddr[3];
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {20'd0, r_pool_base} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_pool_base <= pwdata[PPN_W-1:0];
        end
    end

    sv39ptm_ram #(
        .DEPTH (sv39ptm_pkg::DEPTH),
        .WIDTH (sv39ptm_pkg::PTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    sv39ptm_pte_eval u_eval (
        .i_pte  (mem_rdata),
        .i_base (r_pool_base),
        .o_info (pte_info)
    );

    sv39ptm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_va          (s_axis_tdata[38:0]),
        .i_pa          (s_axis_tdata[94:39]),
        .i_flags       (s_axis_tdata[104:95]),
        .i_base        (r_pool_base),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (out_status),
        .o_unmapped_pa (out_pa),
        .o_mem_en      (mem_en),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_info        (pte_info)
    );

    assign m_axis_tdata = {5'd0, out_pa, out_status};

endmodule

`default_nettype wire

// ----- hdl/sv39ptm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the mapper.
module sv39ptm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One item at a time: the walk takes the block off the input after an accept.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted during a walk");

    // Only the defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= sv39ptm_pkg::STATUS_NOMAP)
        else $error("undefined status code");

    // A removed address is reported only with a good status.
    a_pa_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != sv39ptm_pkg::STATUS_OK)
        |-> m_axis_tdata[58:3] == 56'd0)
        else $error("unmapped address on a failed request");

    // A removed address is always page aligned.
    a_pa_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:3] == 12'd0)
        else $error("unmapped address not page aligned");

endmodule

bind sv39_page_table_mapper_unit sv39ptm_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import sv39ptm_pkg::*;

    // Run limits and APB map.
    localparam int         IDLE_LIMIT    = 40000;
    localparam int         DRAIN_CYCLES  = 32;
    localparam int         PRINT_LIMIT   = 40;
    localparam int         ROOT_TABLE    = 0;
    localparam logic [3:0] ADDR_POOL_BASE = 4'h0;

    // Entry format and page alignment masks.
    localparam logic [PTE_W-1:0] PTE_V   = 54'h1;
    localparam logic [PTE_W-1:0] PTE_RWX = 54'hE;
    localparam logic [PA_W-1:0]  MASK_4K = 56'hFFF;
    localparam logic [PA_W-1:0]  MASK_2M = 56'h1F_FFFF;
    localparam logic [PA_W-1:0]  MASK_1G = 56'h3FFF_FFFF;
    localparam logic [PPN_W-1:0] PPN_ALL_ONES = '1;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [VA_W-1:0]   va;
        logic [PA_W-1:0]   pa;
        logic [FLAG_W-1:0] flags;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PA_W-1:0]     removed_pa;
    } outcome_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    // Shadow page table, allocation pointer and pool base.
    logic [PTE_W-1:0] pt_mem [0:DEPTH-1];
    int unsigned      next_table;
    logic [PPN_W-1:0] pool_base;

    request_t pending_q [$];
    outcome_t outcome_q [$];

    request_t    in_flight;
    int unsigned burst_left;
    int unsigned gap_left;
    logic [31:0] ready_pattern = '1;
    logic [5:0]  pattern_age   = '0;
    int unsigned quiet_cycles  = 0;

    int accepted_count = 0;
    int checked_count  = 0;
    int mismatch_count = 0;
    int base_settings  = 0;
    int status_hist [0:7];

    sv39_page_table_mapper_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned entry_addr(input int unsigned tbl,
                                               input logic [IDX_W-1:0] idx);
        return tbl * TABLE_ENTRIES + idx;
    endfunction

    function automatic logic [PA_W-1:0] page_mask_of(input logic [REQ_W-1:0] kind);
        case (kind)
            REQ_MAP_2M: return MASK_2M;
            REQ_MAP_1G: return MASK_1G;
            default:    return MASK_4K;
        endcase
    endfunction

    function automatic logic [VA_W-1:0] page_va(input logic [IDX_W-1:0] i2,
                                                input logic [IDX_W-1:0] i1,
                                                input logic [IDX_W-1:0] i0);
        return {i2, i1, i0, 12'h000};
    endfunction

    // Pool table that a pointer entry names, or POOL_TABLES when it lies outside.
    function automatic int unsigned pool_index_of(input logic [PTE_W-1:0] pte);
        logic [PPN_W-1:0] off;
        off = pte[PTE_W-1:FLAG_W] - pool_base;
        if (off < POOL_TABLES) return off[TBL_W-1:0];
        return POOL_TABLES;
    endfunction

    // Walk through an upper entry on a map; a missing table is taken from the pool.
    task automatic descend_for_map(input int unsigned at, output logic [STATUS_W-1:0] st,
                                   output int unsigned tbl);
        logic [PTE_W-1:0] pte;
        logic [PPN_W-1:0] ppn;
        pte = pt_mem[at];
        st  = STATUS_OK;
        tbl = 0;
        if ((pte & PTE_V) == 0) begin
            if (next_table >= POOL_TABLES) begin
                st = STATUS_EXHAUSTED;
            end else begin
                ppn        = pool_base + PPN_W'(next_table);
                pt_mem[at] = {ppn, {FLAG_W{1'b0}}} | PTE_V;
                tbl        = next_table;
                next_table = next_table + 1;
            end
        end else if ((pte & PTE_RWX) != 0) begin
            st = STATUS_EXISTS;
        end else begin
            tbl = pool_index_of(pte);
            if (tbl >= POOL_TABLES) st = STATUS_EXISTS;
        end
    endtask

    // Walk through an upper entry on an unmap; nothing is allocated.
    task automatic descend_for_unmap(input int unsigned at, output logic [STATUS_W-1:0] st,
                                     output int unsigned tbl);
        logic [PTE_W-1:0] pte;
        pte = pt_mem[at];
        st  = STATUS_OK;
        tbl = 0;
        if ((pte & PTE_V) == 0) begin
            st = STATUS_NOMAP;
        end else if ((pte & PTE_RWX) != 0) begin
            st = STATUS_EXISTS;
        end else begin
            tbl = pool_index_of(pte);
            if (tbl >= POOL_TABLES) st = STATUS_NOMAP;
        end
    endtask

    // Apply one request to the shadow table and queue the result it must produce.
    task automatic predict_page_walk(input request_t rq);
        logic [STATUS_W-1:0] st;
        logic [PA_W-1:0]     removed;
        logic [PA_W-1:0]     mask;
        logic [IDX_W-1:0]    i0, i1, i2;
        int unsigned         t1, t0, at;
        outcome_t            res;
        i0      = rq.va[20:12];
        i1      = rq.va[29:21];
        i2      = rq.va[38:30];
        st      = STATUS_OK;
        removed = '0;
        t1      = 0;
        t0      = 0;
        at      = 0;
        mask    = page_mask_of(rq.kind);
        if (rq.kind == REQ_UNMAP_4K) begin
            if ((rq.va & mask[VA_W-1:0]) != 0) begin
                st = STATUS_UNALIGNED;
            end else begin
                descend_for_unmap(entry_addr(ROOT_TABLE, i2), st, t1);
                if (st == STATUS_OK) descend_for_unmap(entry_addr(t1, i1), st, t0);
                if (st == STATUS_OK) begin
                    at = entry_addr(t0, i0);
                    if ((pt_mem[at] & PTE_V) == 0) begin
                        st = STATUS_NOMAP;
                    end else begin
                        removed    = {pt_mem[at][PTE_W-1:FLAG_W], 12'h000};
                        pt_mem[at] = '0;
                    end
                end
            end
        end else begin
            if ((rq.va & mask[VA_W-1:0]) != 0 || (rq.pa & mask) != 0) begin
                st = STATUS_UNALIGNED;
            end else begin
                if (rq.kind == REQ_MAP_1G) begin
                    at = entry_addr(ROOT_TABLE, i2);
                end else begin
                    descend_for_map(entry_addr(ROOT_TABLE, i2), st, t1);
                    if (st == STATUS_OK) begin
                        if (rq.kind == REQ_MAP_2M) begin
                            at = entry_addr(t1, i1);
                        end else begin
                            descend_for_map(entry_addr(t1, i1), st, t0);
                            at = entry_addr(t0, i0);
                        end
                    end
                end
                // Upper entries allocated above stay in place even if the leaf is refused.
                if (st == STATUS_OK) begin
                    if ((pt_mem[at] & PTE_V) != 0) st = STATUS_EXISTS;
                    else pt_mem[at] = {rq.pa[PA_W-1:12], rq.flags} | PTE_V;
                end
            end
        end
        res.status     = st;
        res.removed_pa = removed;
        outcome_q.push_back(res);
        status_hist[st] = status_hist[st] + 1;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [VA_W-1:0] va,
                                 input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] flags);
        request_t rq;
        rq.kind  = kind;
        rq.va    = va;
        rq.pa    = pa;
        rq.flags = flags;
        pending_q.push_back(rq);
    endtask

    // Random requests, mostly inside a small working set so that tables get reused.
    task automatic queue_random(input int count);
        request_t         rq;
        logic [IDX_W-1:0] i2, i1, i0;
        logic [63:0]      rnd;
        logic [PA_W-1:0]  mask;
        int               roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 40) rq.kind = REQ_UNMAP_4K;
            else if (roll < 76) rq.kind = REQ_MAP_4K;
            else if (roll < 88) rq.kind = REQ_MAP_2M;
            else rq.kind = REQ_MAP_1G;
            rnd = {$urandom, $urandom};
            i2  = $urandom_range(1) ? 9'h1FF : 9'h000;
            case ($urandom_range(2))
                0:       i1 = 9'h000;
                1:       i1 = 9'h005;
                default: i1 = 9'h1FF;
            endcase
            i0 = ($urandom_range(7) == 0) ? 9'h1FF : 9'($urandom_range(6));
            // Now and then anywhere in the address space; this eats pool tables.
            if ($urandom_range(99) < 5) begin
                i2 = rnd[8:0];
                i1 = rnd[17:9];
                i0 = rnd[26:18];
            end
            // Large pages mostly land outside the working set so they do not block it.
            if (rq.kind == REQ_MAP_2M && $urandom_range(3) != 0) i1 = rnd[35:27];
            if (rq.kind == REQ_MAP_1G && $urandom_range(3) != 0) i2 = rnd[44:36];
            mask     = page_mask_of(rq.kind);
            rq.va    = page_va(i2, i1, i0) & ~mask[VA_W-1:0];
            rnd      = {$urandom, $urandom};
            rq.pa    = rnd[PA_W-1:0] & ~mask;
            rq.flags = 10'($urandom);
            if ($urandom_range(99) < 6) begin
                rnd = {$urandom, $urandom};
                if ($urandom_range(1)) rq.va = rq.va | (rnd[VA_W-1:0] & mask[VA_W-1:0]);
                else rq.pa = rq.pa | (rnd[PA_W-1:0] & mask);
            end
            pending_q.push_back(rq);
        end
    endtask

    // Edge cases, run right after reset with the pool base at zero.
    task automatic queue_directed();
        queue_request(REQ_MAP_4K, page_va(0, 0, 0), 56'hFF_FFFF_FFFF_F000, 10'h3FF);
        queue_request(REQ_MAP_4K, page_va(0, 0, 0), 56'h1000, 10'h00F);
        queue_request(REQ_UNMAP_4K, page_va(0, 0, 0), '0, '0);
        queue_request(REQ_UNMAP_4K, page_va(0, 0, 0), '0, '0);
        queue_request(REQ_UNMAP_4K, '1, '1, '1);
        queue_request(REQ_MAP_4K, 39'h1, 56'h0, 10'h00F);
        queue_request(REQ_MAP_4K, page_va(0, 0, 0), 56'h800, 10'h00F);
        queue_request(REQ_MAP_2M, page_va(0, 3, 0), 56'h1000, 10'h00F);
        // A gigapage leaf in the root blocks deeper maps and unmaps below it.
        queue_request(REQ_MAP_1G, page_va(300, 0, 0), 56'h4000_0000, 10'h00E);
        queue_request(REQ_MAP_4K, page_va(300, 7, 7), 56'h2000, 10'h00F);
        queue_request(REQ_UNMAP_4K, page_va(300, 7, 7), '0, '0);
        queue_request(REQ_UNMAP_4K, page_va(100, 0, 0), '0, '0);
        // A megapage leaf with no R/W/X is a pointer; here it names the root table.
        queue_request(REQ_MAP_2M, page_va(0, 1, 0), 56'h0, 10'h000);
        queue_request(REQ_MAP_4K, page_va(0, 1, 3), 56'hAB_CDEF_0123_4000, 10'h3F1);
        queue_request(REQ_UNMAP_4K, page_va(0, 1, 3), '0, '0);
        // The same kind of pointer aimed outside the pool.
        queue_request(REQ_MAP_2M, page_va(0, 2, 0), 56'h20_0000, 10'h000);
        queue_request(REQ_MAP_4K, page_va(0, 2, 0), 56'h3000, 10'h00F);
        queue_request(REQ_UNMAP_4K, page_va(0, 2, 0), '0, '0);
        // A gigapage leaf with no R/W/X also points back at the root.
        queue_request(REQ_MAP_1G, page_va(2, 0, 0), 56'h0, 10'h000);
        queue_request(REQ_MAP_2M, page_va(2, 5, 0), 56'hFF_FFFF_FFE0_0000, 10'h00F);
        queue_request(REQ_UNMAP_4K, page_va(2, 5, 0), '0, '0);
        queue_request(REQ_MAP_4K, '1 & ~MASK_4K[VA_W-1:0], 56'h0, 10'h000);
        queue_request(REQ_UNMAP_4K, '1 & ~MASK_4K[VA_W-1:0], '1, '1);
    endtask

    task automatic write_pool_base(input logic [PPN_W-1:0] ppn);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POOL_BASE;
        pwdata  <= {{(64 - PPN_W){1'b0}}, ppn};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        pool_base = ppn;
        base_settings = base_settings + 1;
    endtask

    // Wait until every request went in and every result came back, then let the block settle.
    task automatic wait_until_drained();
        @(negedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    = 1;
            gap_left      = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_page_walk(in_flight);
                accepted_count = accepted_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left      = gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    in_flight     = pending_q.pop_front();
                    s_axis_tdata  <= {7'd0, in_flight.flags, in_flight.pa, in_flight.va};
                    s_axis_tuser  <= in_flight.kind;
                    s_axis_tvalid <= 1'b1;
                    burst_left    = burst_left - 1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result ready: a rotating pattern that is redrawn whenever the 6-bit age counter wraps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_pattern <= '1;
            pattern_age   <= '0;
        end else begin
            if (pattern_age == 6'h3F) begin
                case ($urandom_range(3))
                    0:       ready_pattern <= '1;
                    1:       ready_pattern <= $urandom;
                    2:       ready_pattern <= $urandom | $urandom;
                    default: ready_pattern <= $urandom & $urandom & $urandom;
                endcase
            end else begin
                ready_pattern <= {ready_pattern[30:0], ready_pattern[31]};
            end
            pattern_age   <= pattern_age + 6'd1;
            m_axis_tready <= ready_pattern[0];
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        outcome_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("result with no request outstanding", m_axis_tdata, '0);
            end else begin
                want = outcome_q.pop_front();
                checked_count = checked_count + 1;
                if (m_axis_tdata[STATUS_W-1:0] !== want.status)
                    report_mismatch("status", 64'(m_axis_tdata[STATUS_W-1:0]),
                                    64'(want.status));
                if (m_axis_tdata[STATUS_W +: PA_W] !== want.removed_pa)
                    report_mismatch("unmapped_pa", 64'(m_axis_tdata[STATUS_W +: PA_W]),
                                    64'(want.removed_pa));
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, outcome_q.size());
            $display("sv39_page_table_mapper_unit regression: fail");
            $finish;
        end
    end

    initial begin
        logic [63:0] rnd;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        for (int i = 0; i < DEPTH; i++) pt_mem[i] = '0;
        for (int i = 0; i < 8; i++) status_hist[i] = 0;
        next_table = 1;
        pool_base  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The base write lands while the block clears its table memory.
        write_pool_base('0);
        queue_directed();
        queue_random(650);
        wait_until_drained();

        // Old pointers are judged against a base that wraps around the PPN range.
        write_pool_base(PPN_ALL_ONES);
        queue_random(200);
        wait_until_drained();

        rnd = {$urandom, $urandom};
        write_pool_base(rnd[PPN_W-1:0]);
        queue_random(200);
        wait_until_drained();

        // Back to the original base; fresh root slots run the pool dry.
        write_pool_base('0);
        for (int k = 0; k < 8; k++)
            queue_request(REQ_MAP_4K, page_va(9'(400 + k), 9'(k), 0), 56'h5000, 10'h00F);
        queue_random(330);
        wait_until_drained();

        $display("Sent %0d page requests over %0d pool base settings; %0d results checked.",
                 accepted_count, base_settings, checked_count);
        $display("Outcomes ok/unaligned/exhausted/exists/nomap: %0d/%0d/%0d/%0d/%0d",
                 status_hist[STATUS_OK], status_hist[STATUS_UNALIGNED],
                 status_hist[STATUS_EXHAUSTED], status_hist[STATUS_EXISTS],
                 status_hist[STATUS_NOMAP]);
        if (mismatch_count == 0) begin
            $display("sv39_page_table_mapper_unit regression: pass");
        end else begin
            $display("sv39_page_table_mapper_unit regression: fail");
        end
        $finish;
    end

endmodule
